// ===== sv/affine_warp_bilinear_sampler_top_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef AFFINE_WARP_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define AFFINE_WARP_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, muted while reset is held.
`define AWBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awbs assertion failed");

// Next-cycle implication, muted while reset is held.
`define AWBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awbs assertion failed");

`endif

// ===== sv/awbs_pkg.sv =====
`default_nettype none
package awbs_pkg;

    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 128;

    localparam int NUM_REGS = 6;

    // Frame is split over four memories by column and row parity, so the four
    // bilinear neighbors always sit in different banks.
    localparam int BANK_W     = (FRAME_WIDTH + 1) / 2;
    localparam int BANK_H     = (FRAME_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_W * BANK_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic signed [43:0] U_MAX = 44'(FRAME_WIDTH - 1) << 16;
    localparam logic signed [43:0] V_MAX = 44'(FRAME_HEIGHT - 1) << 16;

    typedef enum logic [2:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5
    } t_reg_idx;

    localparam logic [31:0] COEF_ONE = 32'h0001_0000;

    typedef logic [NUM_REGS-1:0][31:0] t_coef;

    typedef struct packed {
        logic       func;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       outside;
    } t_out;

    // Mapped coordinate word, end of the address stages.
    typedef struct packed {
        logic               vld;
        logic               func;
        logic [8:0]         col;
        logic [8:0]         row;
        logic [7:0]         pix;
        logic signed [43:0] u;
        logic signed [43:0] v;
    } t_map;

    // Sample control that travels alongside the memory read data.
    typedef struct packed {
        logic       vld;
        logic       outside;
        logic       xodd;
        logic       yodd;
        logic       xclamp;
        logic       yclamp;
        logic [7:0] fx;
        logic [7:0] fy;
    } t_smp;

endpackage
`default_nettype wire

// ===== sv/awbs_ram.sv =====
`default_nettype none
module awbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/awbs_map.sv =====
`default_nettype none
module awbs_map (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire awbs_pkg::t_in i_word,
    input  wire awbs_pkg::t_coef i_coef,
    output awbs_pkg::t_map     o_map
);
    import awbs_pkg::*;

    // stage 1: four 32x10 products
    logic               r_vld1;
    t_in                r_word1;
    logic signed [41:0] r_pxc, r_pxr, r_pyc, r_pyr;
    logic signed [41:0] n_pxc, n_pxr, n_pyc, n_pyr;
    logic signed [9:0]  col_s, row_s;

    // stage 2: sums
    t_map r_map;
    t_map n_map;

    assign col_s = $signed({1'b0, i_word.col});
    assign row_s = $signed({1'b0, i_word.row});

    assign n_pxc = $signed(i_coef[REG_COEF_XX]) * col_s;
    assign n_pxr = $signed(i_coef[REG_COEF_XY]) * row_s;
    assign n_pyc = $signed(i_coef[REG_COEF_YX]) * col_s;
    assign n_pyr = $signed(i_coef[REG_COEF_YY]) * row_s;

    always_comb begin
        n_map      = r_map;
        n_map.vld  = r_vld1;
        n_map.func = r_word1.func;
        n_map.col  = r_word1.col;
        n_map.row  = r_word1.row;
        n_map.pix  = r_word1.pixel_in;
        n_map.u    = 44'(r_pxc) + 44'(r_pxr) + 44'($signed(i_coef[REG_OFFSET_X]));
        n_map.v    = 44'(r_pyc) + 44'(r_pyr) + 44'($signed(i_coef[REG_OFFSET_Y]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_map.vld <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_map  <= n_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word1 <= i_word;
            r_pxc   <= n_pxc;
            r_pxr   <= n_pxr;
            r_pyc   <= n_pyc;
            r_pyr   <= n_pyr;
        end
    end

    assign o_map = r_map;

endmodule
`default_nettype wire

// ===== sv/awbs_fetch.sv =====
`default_nettype none
module awbs_fetch (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire awbs_pkg::t_map i_map,
    output awbs_pkg::t_smp      o_smp,
    output logic [3:0][7:0]     o_quad
);
    import awbs_pkg::*;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [8:0] x, input logic [8:0] y);
        logic [18:0] lin;
        lin = 19'(y[8:1]) * 19'(BANK_W) + 19'(x[8:1]);
        return lin[BANK_AW-1:0];
    endfunction

    logic       outside;
    logic [8:0] x0, y0, x1, y1;
    logic       wr_ok;
    t_smp       n_smp;
    t_smp       r_smp;

    assign outside = (i_map.u < 44'sd0) || (i_map.v < 44'sd0) ||
                     (i_map.u > U_MAX) || (i_map.v > V_MAX);
    assign x0 = i_map.u[24:16];
    assign y0 = i_map.v[24:16];
    assign x1 = x0 + 9'd1;
    assign y1 = y0 + 9'd1;

    assign wr_ok = i_en && i_map.vld && !i_map.func &&
                   ({1'b0, i_map.col} < 10'(FRAME_WIDTH)) &&
                   ({1'b0, i_map.row} < 10'(FRAME_HEIGHT));

    always_comb begin
        n_smp         = r_smp;
        n_smp.vld     = i_map.vld && i_map.func;
        n_smp.outside = outside;
        n_smp.xodd    = x0[0];
        n_smp.yodd    = y0[0];
        n_smp.xclamp  = (x0 == 9'(FRAME_WIDTH - 1));
        n_smp.yclamp  = (y0 == 9'(FRAME_HEIGHT - 1));
        n_smp.fx      = i_map.u[15:8];
        n_smp.fy      = i_map.v[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp.vld <= 1'b0;
        end else if (i_en) begin
            r_smp <= n_smp;
        end
    end

    // bank index = {row parity, column parity}
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [8:0] xs, ys;
        logic       we;

        assign xs = (x0[0] == PX) ? x0 : x1;
        assign ys = (y0[0] == PY) ? y0 : y1;
        assign we = wr_ok && (i_map.col[0] == PX) && (i_map.row[0] == PY);

        awbs_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (bank_addr(i_map.col, i_map.row)),
            .i_wdata (i_map.pix),
            .i_re    (i_en),
            .i_raddr (bank_addr(xs, ys)),
            .o_rdata (o_quad[b])
        );
    end

    assign o_smp = r_smp;

endmodule
`default_nettype wire

// ===== sv/awbs_interp.sv =====
`default_nettype none
module awbs_interp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire awbs_pkg::t_smp i_smp,
    input  wire logic [3:0][7:0] i_quad,
    output logic                o_vld,
    output awbs_pkg::t_out      o_word
);
    import awbs_pkg::*;

    logic [7:0]  p00, p10, p01, p11;
    logic [8:0]  wx0, wx1, wy0, wy1;
    logic [16:0] n_top, n_bot;
    logic [24:0] acc;

    logic        r_vld5, r_out5;
    logic [7:0]  r_fy5;
    logic [16:0] r_top, r_bot;

    logic        r_vld;
    t_out        r_word;
    t_out        n_word;

    // clamped neighbors fold back onto the nearest in-frame neighbor (p00, p01 or p10)
    assign p00 = i_quad[{i_smp.yodd, i_smp.xodd}];
    assign p10 = i_smp.xclamp ? p00 : i_quad[{i_smp.yodd, ~i_smp.xodd}];
    assign p01 = i_smp.yclamp ? p00 : i_quad[{~i_smp.yodd, i_smp.xodd}];
    assign p11 = i_smp.xclamp ? p01 :
                 (i_smp.yclamp ? p10 : i_quad[{~i_smp.yodd, ~i_smp.xodd}]);

    assign wx1 = {1'b0, i_smp.fx};
    assign wx0 = 9'd256 - wx1;
    assign n_top = 17'(p00) * 17'(wx0) + 17'(p10) * 17'(wx1);
    assign n_bot = 17'(p01) * 17'(wx0) + 17'(p11) * 17'(wx1);

    assign wy1 = {1'b0, r_fy5};
    assign wy0 = 9'd256 - wy1;
    assign acc = 25'(r_top) * 25'(wy0) + 25'(r_bot) * 25'(wy1);

    always_comb begin
        n_word.outside   = r_out5;
        n_word.pixel_out = r_out5 ? 8'd0 : acc[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_en) begin
            r_vld5 <= i_smp.vld;
            r_vld  <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out5 <= i_smp.outside;
            r_fy5  <= i_smp.fy;
            r_top  <= n_top;
            r_bot  <= n_bot;
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule
`default_nettype wire

// ===== sv/affine_warp_bilinear_sampler_top.sv =====
`default_nettype none
// Inverse affine warp with bilinear sampling. A write word (func 0) stores one
// 8-bit pixel into the frame store; a sample word (func 1) maps its output
// (col,row) through the Q15.16 inverse matrix and returns one interpolated
// pixel, or 0 with outside set when the source point leaves the frame. Write
// words return nothing. One word is taken every clock while the output is not
// stalled; the pipeline has five register stages (two for the matrix products
// and sums, one for range check, address and memory read, two for the
// horizontal and vertical blends). The frame lives in four parity-banked
// memories so the four neighbors are read together. There is no clearing pass:
// pixels read before they are written give undefined results. A stalled output
// freezes the whole pipeline, so o_stall follows i_stall only while a result is
// held. Matrix registers may only be written while the block is empty.
module affine_warp_bilinear_sampler_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire awbs_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output awbs_pkg::t_out     o_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import awbs_pkg::*;

    t_coef r_coef;
    logic  en;
    t_map  map_w;
    t_smp  smp_w;
    logic [3:0][7:0] quad;

    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_COEF_XX]  <= COEF_ONE;
            r_coef[REG_COEF_XY]  <= '0;
            r_coef[REG_OFFSET_X] <= '0;
            r_coef[REG_COEF_YX]  <= '0;
            r_coef[REG_COEF_YY]  <= COEF_ONE;
            r_coef[REG_OFFSET_Y] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_XX:  r_coef[REG_COEF_XX]  <= i_cfg_data;
                REG_COEF_XY:  r_coef[REG_COEF_XY]  <= i_cfg_data;
                REG_OFFSET_X: r_coef[REG_OFFSET_X] <= i_cfg_data;
                REG_COEF_YX:  r_coef[REG_COEF_YX]  <= i_cfg_data;
                REG_COEF_YY:  r_coef[REG_COEF_YY]  <= i_cfg_data;
                REG_OFFSET_Y: r_coef[REG_OFFSET_Y] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    awbs_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_word  (i_data),
        .i_coef  (r_coef),
        .o_map   (map_w)
    );

    awbs_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_map   (map_w),
        .o_smp   (smp_w),
        .o_quad  (quad)
    );

    awbs_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_smp   (smp_w),
        .i_quad  (quad),
        .o_vld   (o_valid),
        .o_word  (o_data)
    );

endmodule
`default_nettype wire

// ===== sv/awbs_checker.sv =====
`default_nettype none
`include "affine_warp_bilinear_sampler_top_defines.svh"
module awbs_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire logic           o_stall,
    input wire awbs_pkg::t_out o_data
);
    import awbs_pkg::*;

    `AWBS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `AWBS_ASSERT_IMPLY(a_out_zero, i_clk, i_rst_n, o_valid && o_data.outside, o_data.pixel_out == 8'd0)
    `AWBS_ASSERT_IMPLY(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind affine_warp_bilinear_sampler_top awbs_checker u_awbs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .o_data  (o_data)
);
`default_nettype wire

// ===== dv/affine_warp_bilinear_sampler_top_test.sv =====
`default_nettype none
module affine_warp_bilinear_sampler_top_test;
    import awbs_pkg::*;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam logic       FUNC_WRITE  = 1'b0;
    localparam logic       FUNC_SAMPLE = 1'b1;
    localparam int         DRAIN_CYCLES = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_word = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        o_stall, o_valid, o_cfg_ready;
    t_out        o_data;

    affine_warp_bilinear_sampler_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(o_stall), .i_data(in_word),
        .o_valid(o_valid), .i_stall(out_stall), .o_data(o_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]  frame_pix [FRAME_WIDTH*FRAME_HEIGHT];
    bit          frame_set [FRAME_WIDTH*FRAME_HEIGHT];
    logic [31:0] warp_regs [NUM_REGS];

    t_in  pending_words[$];
    t_out expected_pixels[$];
    int   err_count = 0;
    int   mismatch_count = 0;
    bit   idle_on = 1'b1;
    int   send_gap = 0;
    int   stall_left = 0;

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #(12 * 1_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(in_valid && o_stall)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
                send_gap <= idle_on ? $urandom_range(0, 17) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    always @(posedge i_clk) begin
        int   n;
        t_out exp_w;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            n = stall_left;
            if (o_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    err_count++;
                    if (mismatch_count < 10)
                        $display("unexpected result word: pixel %0d outside %0b",
                                 o_data.pixel_out, o_data.outside);
                    mismatch_count++;
                end else begin
                    exp_w = expected_pixels.pop_front();
                    if (o_data.pixel_out !== exp_w.pixel_out ||
                        o_data.outside !== exp_w.outside) begin
                        err_count++;
                        if (mismatch_count < 10)
                            $display("mismatch: exp pixel %0d outside %0b, got %0d %0b",
                                     exp_w.pixel_out, exp_w.outside,
                                     o_data.pixel_out, o_data.outside);
                        mismatch_count++;
                    end
                end
                n = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (n > 0) begin
                out_stall  <= 1'b1;
                stall_left <= n - 1;
            end else begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    function automatic longint sx(logic [31:0] a);
        return longint'(signed'(a));
    endfunction

    task automatic add_write(int col, int row, logic [7:0] pix);
        t_in w;
        w.func = FUNC_WRITE;
        w.col = 9'(col);
        w.row = 9'(row);
        w.pixel_in = pix;
        if (col < FRAME_WIDTH && row < FRAME_HEIGHT) begin
            frame_pix[row*FRAME_WIDTH + col] = pix;
            frame_set[row*FRAME_WIDTH + col] = 1'b1;
        end
        pending_words.push_back(w);
    endtask

    // make sure a neighbor read by the sampler holds written data
    task automatic need_pixel(int x, int y);
        if (!frame_set[y*FRAME_WIDTH + x])
            add_write(x, y, 8'($urandom));
    endtask

    task automatic add_sample(int col, int row);
        longint      u, v;
        int          x0, y0, x1, y1;
        int unsigned fx, fy, top, bot;
        t_out        r;
        t_in         w;
        u = sx(warp_regs[REG_COEF_XX]) * col + sx(warp_regs[REG_COEF_XY]) * row
            + sx(warp_regs[REG_OFFSET_X]);
        v = sx(warp_regs[REG_COEF_YX]) * col + sx(warp_regs[REG_COEF_YY]) * row
            + sx(warp_regs[REG_OFFSET_Y]);
        if (u < 0 || v < 0 || u > longint'(FRAME_WIDTH - 1) * 65536 ||
            v > longint'(FRAME_HEIGHT - 1) * 65536) begin
            r.pixel_out = 8'd0;
            r.outside = 1'b1;
        end else begin
            x0 = int'(u >>> 16);
            y0 = int'(v >>> 16);
            fx = int'((u >>> 8) & 255);
            fy = int'((v >>> 8) & 255);
            x1 = (x0 + 1 < FRAME_WIDTH) ? x0 + 1 : x0;
            y1 = (y0 + 1 < FRAME_HEIGHT) ? y0 + 1 : y0;
            need_pixel(x0, y0);
            need_pixel(x1, y0);
            need_pixel(x0, y1);
            need_pixel(x1, y1);
            top = frame_pix[y0*FRAME_WIDTH + x0] * (256 - fx)
                + frame_pix[y0*FRAME_WIDTH + x1] * fx;
            bot = frame_pix[y1*FRAME_WIDTH + x0] * (256 - fx)
                + frame_pix[y1*FRAME_WIDTH + x1] * fx;
            r.pixel_out = 8'((top * (256 - fy) + bot * fy) >> 16);
            r.outside = 1'b0;
        end
        expected_pixels.push_back(r);
        w.func = FUNC_SAMPLE;
        w.col = 9'(col);
        w.row = 9'(row);
        w.pixel_in = 8'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            warp_regs[idx] = val;
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_pixels.size() > 0 || in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return COEF_ONE;
        endcase
    endfunction

    task automatic load_matrix(int mode);
        logic [31:0] m [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++) begin
            case (mode)
                0: m[i] = (i == REG_OFFSET_X || i == REG_OFFSET_Y)
                          ? 32'($urandom_range(0, (FRAME_WIDTH - 1) * 65536))
                          : 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
                1: m[i] = pick_extreme();
                default: m[i] = $urandom;
            endcase
        end
        cfg_write(REG_COEF_XX, m[REG_COEF_XX]);
        cfg_write(REG_COEF_XY, m[REG_COEF_XY]);
        cfg_write(REG_OFFSET_X, m[REG_OFFSET_X]);
        cfg_write(REG_COEF_YX, m[REG_COEF_YX]);
        cfg_write(REG_COEF_YY, m[REG_COEF_YY]);
        cfg_write(REG_OFFSET_Y, m[REG_OFFSET_Y]);
        if ($urandom_range(0, 2) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    endtask

    task automatic random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 5) == 0)
                    add_write($urandom_range(0, 511), $urandom_range(0, 511), 8'($urandom));
                else
                    add_write($urandom_range(0, FRAME_WIDTH - 1),
                              $urandom_range(0, FRAME_HEIGHT - 1), 8'($urandom));
            end else if ($urandom_range(0, 5) == 0) begin
                add_sample($urandom_range(0, 511), $urandom_range(0, 511));
            end else begin
                add_sample($urandom_range(0, FRAME_WIDTH - 1),
                           $urandom_range(0, FRAME_HEIGHT - 1));
            end
        end
    endtask

    initial begin
        int mode;
        warp_regs[REG_COEF_XX]  = COEF_ONE;
        warp_regs[REG_COEF_XY]  = '0;
        warp_regs[REG_OFFSET_X] = '0;
        warp_regs[REG_COEF_YX]  = '0;
        warp_regs[REG_COEF_YY]  = COEF_ONE;
        warp_regs[REG_OFFSET_Y] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset matrix (identity)
        add_write(0, 0, 8'd255);
        add_write(FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 8'd0);
        add_write(511, 511, 8'hAA);
        add_write(FRAME_WIDTH, 3, 8'h55);
        add_sample(0, 0);
        add_sample(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
        add_sample(FRAME_WIDTH - 1, 0);
        add_sample(0, FRAME_HEIGHT - 1);
        add_sample(FRAME_WIDTH, 0);
        add_sample(0, FRAME_HEIGHT);
        add_sample(511, 511);
        wait_drained();

        // half-pixel shift: fractions in both axes, right edge column falls outside
        cfg_write(REG_OFFSET_X, 32'h0000_8000);
        cfg_write(REG_OFFSET_Y, 32'h0000_80FF);
        add_sample(0, 0);
        add_sample(10, 20);
        add_sample(FRAME_WIDTH - 2, FRAME_HEIGHT - 2);
        add_sample(FRAME_WIDTH - 1, 5);
        // negative offset just below zero
        wait_drained();
        cfg_write(REG_OFFSET_X, 32'hFFFF_FFFF);
        cfg_write(REG_COEF_XY, 32'h0000_00FF);
        cfg_write(REG_COEF_YX, 32'h0000_0100);
        cfg_write(REG_COEF_YY, 32'h0000_C000);
        add_sample(0, 0);
        add_sample(1, 1);
        add_sample(40, 90);
        wait_drained();
        cfg_write(REG_COEF_XX, 32'h8000_0000);
        cfg_write(REG_COEF_YY, 32'h7FFF_FFFF);
        add_sample(0, 0);
        add_sample(1, 0);
        add_sample(0, 1);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            mode = (p % 5 == 3) ? 1 : (p % 5 == 4) ? 2 : 0;
            load_matrix(mode);
            idle_on = ($urandom_range(0, 3) != 0);
            random_items(120);
            wait_drained();
        end
        idle_on = 1'b1;

        if (err_count == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
